[hw/rtl/mwl_pkg.sv]
package mwl_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_INDEX_BITS = 10;
  localparam int QUARTER         = 1 << (SINE_INDEX_BITS - 2);
  localparam int INC_LSB         = 48 - PHASE_BITS;
  localparam int RATE_W          = 24;
  localparam int HZ_W            = 32;
  localparam int OFFSET_W        = 24;
  localparam int SAMPLE_W        = 16;

  localparam logic [HZ_W-1:0] HZ_TO_STEP_RST = 32'd22906492;
  localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;

  // floor(n / d) == (n * ceil(2^74 / d)) >> 74 for any 64-bit n and d below 1024
  localparam int          RECIP_SH  = 74;
  localparam logic [79:0] RECIP_ONE = 80'd1 << RECIP_SH;
  localparam logic [79:0] TAYLOR_RECIP [12] = '{
    (RECIP_ONE + 80'd5) / 80'd6,
    (RECIP_ONE + 80'd19) / 80'd20,
    (RECIP_ONE + 80'd41) / 80'd42,
    (RECIP_ONE + 80'd71) / 80'd72,
    (RECIP_ONE + 80'd109) / 80'd110,
    (RECIP_ONE + 80'd155) / 80'd156,
    (RECIP_ONE + 80'd209) / 80'd210,
    (RECIP_ONE + 80'd271) / 80'd272,
    (RECIP_ONE + 80'd341) / 80'd342,
    (RECIP_ONE + 80'd419) / 80'd420,
    (RECIP_ONE + 80'd505) / 80'd506,
    (RECIP_ONE + 80'd599) / 80'd600
  };

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW_UP   = 3'd3,
    WAVE_SAW_DOWN = 3'd4,
    WAVE_SMOOTH   = 3'd5,
    WAVE_HOLD     = 3'd6
  } wave_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] rnd_from;
    logic signed [SAMPLE_W-1:0] rnd_to;
    logic signed [SAMPLE_W-1:0] held;
  } rnd_state_t;

  typedef logic [QUARTER:0][14:0] sine_tbl_t;

  function automatic longint unsigned recip_div(input longint unsigned n,
                                                input logic [79:0] m);
    logic [143:0] wide;
    wide = 144'(n) * 144'(m);
    return wide[RECIP_SH +: 64];
  endfunction

  // Q30 Taylor series, evaluated at elaboration only
  function automatic logic [14:0] sin_q14(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = recip_div((term * x2) >> 30, TAYLOR_RECIP[n - 1]);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) begin
      sum = 16384;
    end
    return sum[14:0];
  endfunction

  function automatic sine_tbl_t sine_build();
    sine_tbl_t       tbl;
    longint unsigned x;
    for (int k = 0; k <= QUARTER; k++) begin
      x      = (longint'(k) * HALF_PI_Q30 + (QUARTER >> 1)) >> (SINE_INDEX_BITS - 2);
      tbl[k] = sin_q14(x);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = sine_build();

endpackage

[hw/rtl/mwl_wave.sv]
module mwl_wave
  import mwl_pkg::*;
(
  input  logic [2:0]                 wave,
  input  logic [PHASE_BITS-1:0]      phase,
  input  rnd_state_t                 rnd,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int SH = PHASE_BITS - SINE_INDEX_BITS;
  localparam logic [PHASE_BITS-1:0] HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);

  logic [PHASE_BITS:0]            rsum;
  logic [SINE_INDEX_BITS-1:0]     idx;
  logic [1:0]                     quad;
  logic [SINE_INDEX_BITS-3:0]     r;
  logic [SINE_INDEX_BITS-2:0]     tidx;
  logic [14:0]                    sv;
  logic signed [SAMPLE_W-1:0]     sine_s;

  logic [PHASE_BITS-1:0]          adist;
  logic [PHASE_BITS+1:0]          tri_w;
  logic [15:0]                    tri_u;
  logic signed [16:0]             tri_s;

  logic [14:0]                    saw_u;
  logic signed [SAMPLE_W-1:0]     saw_up;
  logic signed [SAMPLE_W-1:0]     saw_dn;

  logic signed [16:0]             diff;
  logic signed [PHASE_BITS+17:0]  prod;
  logic signed [16:0]             smooth;

  always_comb begin
    rsum   = {1'b0, phase} + ((PHASE_BITS + 1)'(1) << (SH - 1));
    idx    = rsum[PHASE_BITS-1:SH];
    quad   = idx[SINE_INDEX_BITS-1:SINE_INDEX_BITS-2];
    r      = idx[SINE_INDEX_BITS-3:0];
    tidx   = quad[0] ? ((SINE_INDEX_BITS - 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    sv     = SINE_TBL[tidx];
    sine_s = quad[1] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});

    adist  = phase[PHASE_BITS-1] ? (phase - HALF) : (HALF - phase);
    tri_w  = {adist, 2'b00};
    tri_u  = tri_w[PHASE_BITS+1:PHASE_BITS-14];
    tri_s  = $signed({1'b0, tri_u}) - 17'sd16384;

    saw_u  = phase[PHASE_BITS-1 -: 15];
    saw_up = $signed({1'b0, saw_u}) - 16'sd16384;
    saw_dn = 16'sd16384 - $signed({1'b0, saw_u});

    diff   = 17'(rnd.rnd_to) - 17'(rnd.rnd_from);
    prod   = diff * $signed({1'b0, phase});
    smooth = 17'(rnd.rnd_from) + prod[PHASE_BITS+16:PHASE_BITS];

    case (wave)
      WAVE_SINE:     sample = sine_s;
      WAVE_TRIANGLE: sample = tri_s[SAMPLE_W-1:0];
      WAVE_SQUARE:   sample = phase[PHASE_BITS-1] ? -16'sd16384 : 16'sd16384;
      WAVE_SAW_UP:   sample = saw_up;
      WAVE_SAW_DOWN: sample = saw_dn;
      WAVE_SMOOTH:   sample = smooth[SAMPLE_W-1:0];
      WAVE_HOLD:     sample = rnd.held;
      default:       sample = '0;
    endcase
  end

endmodule

[hw/rtl/mwl_osc_state.sv]
module mwl_osc_state
  import mwl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [OFFSET_W-1:0]   offset,
  input  logic [PHASE_BITS-1:0] inc,
  output logic [PHASE_BITS-1:0] rd_phase,
  output logic                  wrap,
  output rnd_state_t            rnd
);

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [31:0]           rng_r;
  logic [31:0]           rng_a;
  logic [31:0]           rng_b;
  rnd_state_t            rnd_r;
  logic [OFFSET_W+31:0]  off_ext;

  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_rnd(input logic [31:0] v);
    return $signed({1'b0, v[15:1]}) - 16'sd16384;
  endfunction

  always_comb begin
    off_ext              = {offset, 32'd0};
    rd_phase             = phase_r + off_ext[OFFSET_W+31 -: PHASE_BITS];
    {wrap, phase_nxt}    = {1'b0, phase_r} + {1'b0, inc};
    rng_a                = xs32(rng_r);
    rng_b                = xs32(rng_a);
    rnd                  = rnd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rng_r   <= 32'd1;
      rnd_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      if (wrap) begin
        rng_r          <= rng_b;
        rnd_r.rnd_from <= rnd_r.rnd_to;
        rnd_r.rnd_to   <= to_rnd(rng_a);
        rnd_r.held     <= to_rnd(rng_b);
      end
    end
  end

  a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n) rng_r != '0)
    else $error("random word reached zero");
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r))
    else $error("phase moved without an item");
  a_rng_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !wrap) |=> $stable(rng_r))
    else $error("random word moved without a wrap");

endmodule

[hw/rtl/multi_wave_lfo.sv]
// multi_wave_lfo: low-frequency oscillator, one signed Q2.14 sample per tick.
// Input channel (in_valid/in_stall): one tick item with in_waveform, in_rate
// and in_phase_offset. Result channel (out_valid/out_stall): out_sample and
// out_cycle_wrapped. An item is taken at an edge where valid is high and
// stall is low. Config channel (cfg_valid/cfg_ready, always ready) writes
// hz_to_step; write it only while no item is in flight.
// An item that is taken is held in the input register and moves into the
// result register, which drives out_valid, once that is empty or its result
// is taken. The phase increment multiply (rate by hz_to_step), waveform
// generation and the phase/random update all sit between the input and the
// result registers. Throughput: one item per cycle while out_stall is low.
// Reset (rst_n low at a clock edge): phase 0, random word 1, random points
// and held value 0, hz_to_step 22906492, both item registers empty.
// When the receiver stalls, the result holds; one more item is taken into
// the input register, after which in_stall follows out_stall.
module multi_wave_lfo
  import mwl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_waveform,
  input  logic [RATE_W-1:0]          in_rate,
  input  logic [OFFSET_W-1:0]        in_phase_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_cycle_wrapped,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [HZ_W-1:0]            cfg_data
);

  logic [HZ_W-1:0]            hz_r;
  logic                       a_valid_r;
  logic [2:0]                 a_wave_r;
  logic [OFFSET_W-1:0]        a_offset_r;
  logic [RATE_W-1:0]          a_rate_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_wrap_r;

  logic [RATE_W+HZ_W-1:0]     inc_prod;
  logic                       adv;
  logic                       take;
  logic [PHASE_BITS-1:0]      rd_phase;
  logic                       wrap;
  rnd_state_t                 rnd;
  logic signed [SAMPLE_W-1:0] sample;

  assign inc_prod  = a_rate_r * hz_r;
  assign adv       = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = a_valid_r && !adv;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_sample        = out_sample_r;
  assign out_cycle_wrapped = out_wrap_r;

  mwl_osc_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .offset   (a_offset_r),
    .inc      (inc_prod[INC_LSB +: PHASE_BITS]),
    .rd_phase (rd_phase),
    .wrap     (wrap),
    .rnd      (rnd)
  );

  mwl_wave u_wave (
    .wave   (a_wave_r),
    .phase  (rd_phase),
    .rnd    (rnd),
    .sample (sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r        <= HZ_TO_STEP_RST;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hz_r <= cfg_data;
      end
      if (take) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_wave_r   <= in_waveform;
      a_offset_r <= in_phase_offset;
      a_rate_r   <= in_rate;
    end
    if (adv) begin
      out_sample_r <= sample;
      out_wrap_r   <= wrap;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room downstream");
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item not presented");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !adv) |=> !out_valid_r)
    else $error("result repeated after delivery");
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !adv) |=> a_valid_r)
    else $error("pending item dropped");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mwl_pkg::*;

  localparam logic [2:0] WAVE_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_SETTINGS = 7;
  localparam int RANDOM_PER_SETTING = 205;

  typedef struct {
    logic [2:0]          waveform;
    logic [RATE_W-1:0]   rate;
    logic [OFFSET_W-1:0] offset;
  } tick_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       wrapped;
  } lfo_out_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 in_waveform;
  logic [RATE_W-1:0]          in_rate;
  logic [OFFSET_W-1:0]        in_phase_offset;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_cycle_wrapped;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [HZ_W-1:0]            cfg_data;

  multi_wave_lfo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_waveform       (in_waveform),
    .in_rate           (in_rate),
    .in_phase_offset   (in_phase_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_cycle_wrapped (out_cycle_wrapped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // oscillator state mirror
  int                         sine_quarter [QUARTER+1];
  logic [HZ_W-1:0]            hz_step;
  logic [PHASE_BITS-1:0]      lfo_phase;
  logic [31:0]                rng_state;
  logic signed [SAMPLE_W-1:0] rnd_from;
  logic signed [SAMPLE_W-1:0] rnd_to;
  logic signed [SAMPLE_W-1:0] rnd_held;

  tick_t           tick_q [$];
  lfo_out_t        expected_samples [$];
  logic [HZ_W-1:0] hz_settings [N_SETTINGS];

  bit item_taken;
  bit tx_calm;
  bit rx_calm;
  int in_gap;
  int out_hold_left;
  int mismatches;
  int idle_cycles;

  function automatic int taylor_sin_q14(input longint unsigned x);
    longint unsigned x_sq;
    longint unsigned t;
    longint          acc;
    x_sq = (x * x) >> 30;
    t    = x;
    acc  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      t = ((t * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) begin
      acc = 16384;
    end
    return int'(acc);
  endfunction

  function automatic int sine_lookup(input logic [PHASE_BITS-1:0] p);
    logic [PHASE_BITS:0]        rp;
    logic [SINE_INDEX_BITS-1:0] idx;
    logic [1:0]                 quad;
    int                         r;
    int                         v;
    rp   = {1'b0, p} + (1 << (PHASE_BITS - SINE_INDEX_BITS - 1));
    idx  = rp[PHASE_BITS-1 -: SINE_INDEX_BITS];
    quad = idx[SINE_INDEX_BITS-1 -: 2];
    r    = int'(idx[SINE_INDEX_BITS-3:0]);
    v    = quad[0] ? sine_quarter[QUARTER - r] : sine_quarter[r];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_random_point();
    rng_state = rng_state ^ (rng_state << 13);
    rng_state = rng_state ^ (rng_state >> 17);
    rng_state = rng_state ^ (rng_state << 5);
    return SAMPLE_W'(int'({1'b0, rng_state[15:1]}) - 16384);
  endfunction

  // computes the sample for one tick and advances the oscillator
  function automatic lfo_out_t lfo_tick(input tick_t t);
    logic [PHASE_BITS-1:0] p;
    logic [PHASE_BITS-1:0] nxt;
    logic [PHASE_BITS:0]   d;
    logic [55:0]           prod;
    longint                span;
    int                    s;
    lfo_out_t              r;
    p = lfo_phase + t.offset;
    s = 0;
    case (t.waveform)
      WAVE_SINE: s = sine_lookup(p);
      WAVE_TRIANGLE: begin
        if (p[PHASE_BITS-1]) begin
          d = {p, 1'b0} - (1 << PHASE_BITS);
        end else begin
          d = (1 << PHASE_BITS) - {p, 1'b0};
        end
        s = int'({d, 1'b0} >> (PHASE_BITS - 14)) - 16384;
      end
      WAVE_SQUARE:   s = p[PHASE_BITS-1] ? -16384 : 16384;
      WAVE_SAW_UP:   s = int'(p >> (PHASE_BITS - 15)) - 16384;
      WAVE_SAW_DOWN: s = 16384 - int'(p >> (PHASE_BITS - 15));
      WAVE_SMOOTH: begin
        span = (longint'(rnd_to) - longint'(rnd_from)) * longint'(p);
        s    = int'(rnd_from) + int'(span >>> PHASE_BITS);
      end
      WAVE_HOLD: s = int'(rnd_held);
      default:   s = 0;
    endcase
    prod      = 56'(t.rate) * 56'(hz_step);
    nxt       = lfo_phase + prod[INC_LSB +: PHASE_BITS];
    r.wrapped = (nxt < lfo_phase);
    lfo_phase = nxt;
    if (r.wrapped) begin
      rnd_from = rnd_to;
      rnd_to   = next_random_point();
      rnd_held = next_random_point();
    end
    r.sample = s[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    t.waveform = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      t.rate = RATE_W'($urandom);
    end else if (pick == 1) begin
      t.rate = RATE_W'($urandom_range(0, 65535));
    end else if (pick == 2) begin
      t.rate = RATE_W'($urandom >> $urandom_range(8, 31));
    end else begin
      t.rate = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    if ($urandom_range(0, 7) == 0) begin
      t.offset = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end else begin
      t.offset = OFFSET_W'($urandom);
    end
    return t;
  endfunction

  task automatic add_tick(input logic [2:0] wave, input logic [RATE_W-1:0] rate,
                          input logic [OFFSET_W-1:0] offset);
    tick_t t;
    t.waveform = wave;
    t.rate     = rate;
    t.offset   = offset;
    tick_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hz(input logic [HZ_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    hz_step = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    end
  endtask

  // input side: acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tick_t t;
      t.waveform = in_waveform;
      t.rate     = in_rate;
      t.offset   = in_phase_offset;
      expected_samples.push_back(lfo_tick(t));
      item_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_ticks
    tick_t t;
    if (rst_n && (!in_valid || item_taken)) begin
      item_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        t = tick_q.pop_front();
        in_valid        <= 1'b1;
        in_waveform     <= t.waveform;
        in_rate         <= t.rate;
        in_phase_offset <= t.offset;
        if ($urandom_range(0, 49) == 0) begin
          tx_calm = !tx_calm;
        end
        in_gap = tx_calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (out_hold_left > 0) begin
      out_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lfo_out_t e;
      if (expected_samples.size() == 0) begin
        note_mismatch("item with nothing expected, sample", 0, out_sample);
      end else begin
        e = expected_samples.pop_front();
        if (out_sample !== e.sample) begin
          note_mismatch("sample", e.sample, out_sample);
        end
        if (out_cycle_wrapped !== e.wrapped) begin
          note_mismatch("cycle_wrapped", e.wrapped, out_cycle_wrapped);
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        rx_calm = !rx_calm;
      end
      out_hold_left = rx_calm ? 0 : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL multi_wave_lfo");
      $finish;
    end
  end

  initial begin
    longint unsigned x;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_waveform     = '0;
    in_rate         = '0;
    in_phase_offset = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    item_taken      = 1'b0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    in_gap          = 0;
    out_hold_left   = 0;
    mismatches      = 0;
    idle_cycles     = 0;

    for (int k = 0; k <= QUARTER; k++) begin
      x = (longint'(k) * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
      sine_quarter[k] = taylor_sin_q14(x);
    end
    hz_step   = HZ_TO_STEP_RST;
    lfo_phase = '0;
    rng_state = 32'd1;
    rnd_from  = '0;
    rnd_to    = '0;
    rnd_held  = '0;

    hz_settings[0] = HZ_TO_STEP_RST;
    hz_settings[1] = '0;
    hz_settings[2] = '1;
    hz_settings[3] = 32'h0200_0000;
    hz_settings[4] = $urandom;
    hz_settings[5] = 32'h0001_0000;
    hz_settings[6] = HZ_TO_STEP_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_hz(hz_settings[ph]);
      end
      if (ph == 0) begin
        add_tick(WAVE_SINE,     '0, '0);
        add_tick(WAVE_TRIANGLE, '0, '0);
        add_tick(WAVE_SQUARE,   '0, '0);
        add_tick(WAVE_SAW_UP,   '0, '0);
        add_tick(WAVE_SAW_DOWN, '0, '0);
        add_tick(WAVE_SMOOTH,   '0, '0);
        add_tick(WAVE_HOLD,     '0, '0);
        add_tick(WAVE_UNUSED,   '0, '0);
        add_tick(WAVE_SINE,     '0, 24'h7F_FFFF);
        add_tick(WAVE_SINE,     '0, 24'h80_0000);
        add_tick(WAVE_SINE,     '0, '1);
        add_tick(WAVE_TRIANGLE, '0, 24'h80_0000);
        add_tick(WAVE_TRIANGLE, '0, '1);
        add_tick(WAVE_SAW_UP,   '0, '1);
        add_tick(WAVE_SAW_DOWN, '0, '1);
        add_tick(WAVE_SQUARE,   '0, 24'h7F_FFFF);
        add_tick(WAVE_SQUARE,   '0, 24'h80_0000);
        // max rate until the phase wraps and the random points move
        add_tick(WAVE_HOLD,     '1, '0);
        add_tick(WAVE_SMOOTH,   '1, 24'h40_0000);
        add_tick(WAVE_HOLD,     '1, '0);
        add_tick(WAVE_SMOOTH,   '1, '1);
        add_tick(WAVE_UNUSED,   '1, '1);
      end
      if (ph == 3) begin
        // increment of exactly one cycle, then of nearly two
        add_tick(WAVE_SAW_UP, 24'h80_0000, '0);
        add_tick(WAVE_SAW_UP, '1, '0);
        add_tick(WAVE_SMOOTH, 24'h80_0000, 24'h12_3456);
      end
      for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
        if (i == RANDOM_PER_SETTING / 2) begin
          wait_drained();
        end
        tick_q.push_back(random_tick());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("PASS multi_wave_lfo");
    end else begin
      $display("FAIL multi_wave_lfo");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mwl_pkg.sv
hw/rtl/mwl_wave.sv
hw/rtl/mwl_osc_state.sv
hw/rtl/multi_wave_lfo.sv
test/tb_top.sv
